/* src/wplt_pkg.sv */
`timescale 1ns / 1ps

package wplt_pkg;

  // Input transaction as it arrives on the command port.
  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  obs;
    logic [5:0]  label_a;
    logic [5:0]  label_b;
    logic [15:0] weight;
  } in_item_t;

  // Result transaction as it leaves the block.
  typedef struct packed {
    logic        status;
    logic [5:0]  label;
    logic [10:0] label_size;
    logic [25:0] label_weight;
    logic [6:0]  used_count;
    logic [63:0] used_mask;
  } out_item_t;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_MOVE  = 3'd1;
  localparam logic [2:0] MODE_MERGE = 3'd2;
  localparam logic [2:0] MODE_SETW  = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Configuration port.
  localparam int         CFG_IDX_W       = 2;
  localparam int         CFG_DATA_W      = 11;
  localparam logic [1:0] CFG_OBS_COUNT   = 2'd0;
  localparam logic [1:0] CFG_LABEL_COUNT = 2'd1;

  localparam logic [10:0] OBS_COUNT_RST   = 11'd1024;
  localparam logic [6:0]  LABEL_COUNT_RST = 7'd64;

  // Output field limits.
  localparam logic [10:0] SIZE_MAX_OUT = 11'h7FF;
  localparam logic [25:0] SUM_MAX_OUT  = 26'h3FFFFFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_OBS,
    S_SCAN,
    S_LAB,
    S_WR2
  } state_t;

  // What the label stage does with the label table data.
  typedef enum logic [1:0] {
    LOP_REPORT,
    LOP_SETW,
    LOP_XFER
  } lab_op_t;

endpackage

/* src/weighted_partition_label_table.sv */
`timescale 1ns / 1ps

// Weighted partition label table. Each observation holds a label and a weight in
// an observation memory; each label holds a member count and a weight sum in a
// label memory with two read ports. A command is taken when start is high and
// busy is low, and its result is shown on out_data for one cycle with out_valid
// high, in the cycle after the last state of the command; the receiver cannot hold
// it off. An out-of-range index gives its result straight from the idle state;
// query and set weight take one observation read and one label read; move takes
// the same and, when the label changes, a second label write through the single
// write port; merge of a label with itself takes one label read; merge of two
// distinct labels reads the observation memory once per observation in use
// (obs_count taken as 1 when zero and as MAX_OBS when larger), one per cycle, and
// then writes both labels; init runs the clearing pass, which writes one entry of
// each memory per cycle over max(MAX_OBS, MAX_LABELS) entries. The same clearing
// pass runs after reset and after every write to a register (busy is high
// throughout, and also in any cycle in which cfg_we is high); it produces no result.
module weighted_partition_label_table #(
  parameter int MAX_OBS     = 1024,
  parameter int MAX_LABELS  = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  wplt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output wplt_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [wplt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wplt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import wplt_pkg::*;

  localparam int OBS_AW = $clog2(MAX_OBS);
  localparam int LAB_AW = $clog2(MAX_LABELS);
  localparam int CNT_W  = $clog2(MAX_OBS + 1);
  localparam int SUM_W  = CNT_W + WEIGHT_BITS;
  localparam int UC_W   = $clog2(MAX_LABELS + 1);
  localparam int SWEEP  = (MAX_OBS > MAX_LABELS) ? MAX_OBS : MAX_LABELS;
  localparam int IW     = $clog2(SWEEP + 1);
  localparam int NW     = (CNT_W > 11) ? CNT_W : 11;
  localparam int SMW    = (SUM_W > 26) ? SUM_W : 26;
  localparam int WX     = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;
  localparam int OW     = LAB_AW + WEIGHT_BITS;
  localparam int LW     = CNT_W + SUM_W;

  // Memories.
  logic [OW-1:0] obs_mem [MAX_OBS];
  logic [LW-1:0] lab_mem [MAX_LABELS];
  logic [OW-1:0] obs_rdata_r;
  logic [LW-1:0] lab_rdata_a_r;
  logic [LW-1:0] lab_rdata_b_r;

  // Memory port controls.
  logic              obs_we;
  logic [OBS_AW-1:0] obs_wa;
  logic [OW-1:0]     obs_wd;
  logic [OBS_AW-1:0] obs_ra;
  logic              lab_we;
  logic [LAB_AW-1:0] lab_wa;
  logic [LW-1:0]     lab_wd;
  logic [LAB_AW-1:0] lab_ra_a;
  logic [LAB_AW-1:0] lab_ra_b;

  // Control and working registers.
  state_t             state_r, state_nxt;
  lab_op_t            lop_r, lop_nxt;
  logic [2:0]         mode_r, mode_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic [OBS_AW-1:0]  pend_addr_r, pend_addr_nxt;
  logic [OBS_AW-1:0]  obs_addr_r, obs_addr_nxt;
  logic [LAB_AW-1:0]  src_r, src_nxt;
  logic [LAB_AW-1:0]  dst_r, dst_nxt;
  logic [WEIGHT_BITS-1:0] new_w_r, new_w_nxt;
  logic [CNT_W-1:0]   d_cnt_r, d_cnt_nxt;
  logic [SUM_W-1:0]   d_w_r, d_w_nxt;
  logic [CNT_W-1:0]   dst_cnt_r, dst_cnt_nxt;
  logic [SUM_W-1:0]   dst_sum_r, dst_sum_nxt;
  logic [MAX_LABELS-1:0] used_r, used_nxt;
  logic [UC_W-1:0]    used_cnt_r, used_cnt_nxt;
  logic [10:0]        obs_count_r, obs_count_nxt;
  logic [6:0]         label_count_r, label_count_nxt;
  logic               init_rep_r, init_rep_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  // Effective sizes, with zero taken as one and large values clamped.
  logic [NW-1:0]    obs_count_ext;
  logic [CNT_W-1:0] n_obs;
  logic [6:0]       n_lab;

  always_comb begin
    obs_count_ext = NW'(obs_count_r);
    if (obs_count_ext == '0) begin
      n_obs = CNT_W'(1);
    end else if (obs_count_ext > NW'(MAX_OBS)) begin
      n_obs = CNT_W'(MAX_OBS);
    end else begin
      n_obs = obs_count_ext[CNT_W-1:0];
    end
    if (label_count_r == 7'd0) begin
      n_lab = 7'd1;
    end else if (label_count_r > 7'(MAX_LABELS)) begin
      n_lab = 7'(MAX_LABELS);
    end else begin
      n_lab = label_count_r;
    end
  end

  // Decode of the incoming command.
  logic [NW-1:0]      obs_ext;
  logic               obs_bad, la_bad, lb_bad;
  logic [OBS_AW-1:0]  in_obs_addr;
  logic [LAB_AW-1:0]  la_addr, lb_addr, mrg_dst, mrg_src;
  logic [WX-1:0]      in_w_ext;
  logic [WEIGHT_BITS-1:0] in_w;
  logic               accept;

  assign obs_ext     = NW'(in_data.obs);
  assign obs_bad     = obs_ext >= NW'(n_obs);
  assign la_bad      = 7'(in_data.label_a) >= n_lab;
  assign lb_bad      = 7'(in_data.label_b) >= n_lab;
  assign in_obs_addr = obs_ext[OBS_AW-1:0];
  assign la_addr     = in_data.label_a[LAB_AW-1:0];
  assign lb_addr     = in_data.label_b[LAB_AW-1:0];
  assign mrg_dst     = (la_addr < lb_addr) ? la_addr : lb_addr;
  assign mrg_src     = (la_addr < lb_addr) ? lb_addr : la_addr;
  assign in_w_ext    = WX'(in_data.weight);
  assign in_w        = in_w_ext[WEIGHT_BITS-1:0];
  assign busy        = (state_r != S_IDLE) || cfg_we;
  assign accept      = start && !busy;

  // Fields of the memory read data.
  logic [LAB_AW-1:0]      rd_label;
  logic [WEIGHT_BITS-1:0] rd_weight;
  logic [CNT_W-1:0]       a_cnt, b_cnt;
  logic [SUM_W-1:0]       a_sum, b_sum;

  assign rd_label  = obs_rdata_r[OW-1:WEIGHT_BITS];
  assign rd_weight = obs_rdata_r[WEIGHT_BITS-1:0];
  assign a_cnt     = lab_rdata_a_r[LW-1:SUM_W];
  assign a_sum     = lab_rdata_a_r[SUM_W-1:0];
  assign b_cnt     = lab_rdata_b_r[LW-1:SUM_W];
  assign b_sum     = lab_rdata_b_r[SUM_W-1:0];

  // Label updates for a transfer of members and for a weight change.
  logic [CNT_W-1:0] src_cnt_new, dst_cnt_new;
  logic [SUM_W-1:0] src_sum_new, dst_sum_new, setw_sum;
  logic             clr_src, set_dst;

  assign src_cnt_new = a_cnt - d_cnt_r;
  assign src_sum_new = a_sum - d_w_r;
  assign dst_cnt_new = b_cnt + d_cnt_r;
  assign dst_sum_new = b_sum + d_w_r;
  assign setw_sum    = b_sum - d_w_r + SUM_W'(new_w_r);
  assign clr_src     = (src_cnt_new == '0) && used_r[src_r];
  assign set_dst     = (d_cnt_r != '0) && !used_r[dst_r];

  // Saturation of counts and sums to the output field widths.
  function automatic logic [10:0] sat_size(input logic [CNT_W-1:0] v);
    logic [NW-1:0] e;
    e = NW'(v);
    return (e > NW'(SIZE_MAX_OUT)) ? SIZE_MAX_OUT : e[10:0];
  endfunction

  function automatic logic [25:0] sat_sum(input logic [SUM_W-1:0] v);
    logic [SMW-1:0] e;
    e = SMW'(v);
    return (e > SMW'(SUM_MAX_OUT)) ? SUM_MAX_OUT : e[25:0];
  endfunction

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    state_nxt       = state_r;
    lop_nxt         = lop_r;
    mode_nxt        = mode_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    pend_addr_nxt   = pend_addr_r;
    obs_addr_nxt    = obs_addr_r;
    src_nxt         = src_r;
    dst_nxt         = dst_r;
    new_w_nxt       = new_w_r;
    d_cnt_nxt       = d_cnt_r;
    d_w_nxt         = d_w_r;
    dst_cnt_nxt     = dst_cnt_r;
    dst_sum_nxt     = dst_sum_r;
    used_nxt        = used_r;
    used_cnt_nxt    = used_cnt_r;
    obs_count_nxt   = obs_count_r;
    label_count_nxt = label_count_r;
    init_rep_nxt    = init_rep_r;
    out_valid_nxt   = 1'b0;

    out_nxt              = out_r;
    out_nxt.status       = STATUS_OK;
    out_nxt.label        = '0;
    out_nxt.label_size   = '0;
    out_nxt.label_weight = '0;
    out_nxt.used_count   = 7'(used_cnt_r);
    out_nxt.used_mask    = 64'(used_r);

    obs_we   = 1'b0;
    obs_wa   = obs_addr_r;
    obs_wd   = '0;
    obs_ra   = in_obs_addr;
    lab_we   = 1'b0;
    lab_wa   = dst_r;
    lab_wd   = '0;
    lab_ra_a = src_r;
    lab_ra_b = dst_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt     = in_data.mode;
          obs_addr_nxt = in_obs_addr;
          new_w_nxt    = in_w;
          case (in_data.mode)
            MODE_INIT: begin
              idx_nxt      = '0;
              init_rep_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            MODE_MOVE: begin
              if (obs_bad || la_bad) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STATUS_ERR;
              end else begin
                dst_nxt   = la_addr;
                state_nxt = S_OBS;
              end
            end
            MODE_MERGE: begin
              if (la_bad || lb_bad) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STATUS_ERR;
              end else if (mrg_dst == mrg_src) begin
                // Merging a label with itself only reports it.
                dst_nxt   = mrg_dst;
                lab_ra_b  = mrg_dst;
                lop_nxt   = LOP_REPORT;
                state_nxt = S_LAB;
              end else begin
                dst_nxt   = mrg_dst;
                src_nxt   = mrg_src;
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
                d_cnt_nxt = '0;
                d_w_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // Set weight and query; unknown modes act as query.
              if (obs_bad) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STATUS_ERR;
              end else begin
                state_nxt = S_OBS;
              end
            end
          endcase
        end
      end

      S_CLEAR: begin
        // One entry of each memory per cycle; label 0 takes all observations.
        used_nxt     = MAX_LABELS'(1);
        used_cnt_nxt = UC_W'(1);
        obs_wa       = idx_r[OBS_AW-1:0];
        obs_wd       = OW'(1);
        obs_we       = idx_r < IW'(MAX_OBS);
        lab_wa       = idx_r[LAB_AW-1:0];
        lab_we       = idx_r < IW'(MAX_LABELS);
        if (idx_r == '0) begin
          lab_wd = {n_obs, SUM_W'(n_obs)};
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(SWEEP - 1)) begin
          state_nxt    = S_IDLE;
          init_rep_nxt = 1'b0;
          if (init_rep_r) begin
            out_valid_nxt        = 1'b1;
            out_nxt.label_size   = sat_size(n_obs);
            out_nxt.label_weight = sat_sum(SUM_W'(n_obs));
          end
        end
      end

      S_OBS: begin
        case (mode_r)
          MODE_MOVE: begin
            if (rd_label == dst_r) begin
              lop_nxt = LOP_REPORT;
            end else begin
              obs_we    = 1'b1;
              obs_wd    = {dst_r, rd_weight};
              src_nxt   = rd_label;
              lab_ra_a  = rd_label;
              d_cnt_nxt = CNT_W'(1);
              d_w_nxt   = SUM_W'(rd_weight);
              lop_nxt   = LOP_XFER;
            end
          end
          MODE_SETW: begin
            obs_we   = 1'b1;
            obs_wd   = {rd_label, new_w_r};
            dst_nxt  = rd_label;
            lab_ra_b = rd_label;
            d_w_nxt  = SUM_W'(rd_weight);
            lop_nxt  = LOP_SETW;
          end
          default: begin
            dst_nxt  = rd_label;
            lab_ra_b = rd_label;
            lop_nxt  = LOP_REPORT;
          end
        endcase
        state_nxt = S_LAB;
      end

      S_SCAN: begin
        // Issue one read per cycle and relabel the entry whose read was issued in the previous cycle.
        obs_ra = idx_r[OBS_AW-1:0];
        if (idx_r < IW'(n_obs)) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[OBS_AW-1:0];
          idx_nxt       = idx_r + IW'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (rd_label == src_r)) begin
          obs_we    = 1'b1;
          obs_wa    = pend_addr_r;
          obs_wd    = {dst_r, rd_weight};
          d_cnt_nxt = d_cnt_r + CNT_W'(1);
          d_w_nxt   = d_w_r + SUM_W'(rd_weight);
        end
        if (!pend_r && (idx_r == IW'(n_obs))) begin
          lop_nxt   = LOP_XFER;
          state_nxt = S_LAB;
        end
      end

      S_LAB: begin
        case (lop_r)
          LOP_SETW: begin
            lab_we               = 1'b1;
            lab_wa               = dst_r;
            lab_wd               = {b_cnt, setw_sum};
            out_valid_nxt        = 1'b1;
            out_nxt.label        = 6'(dst_r);
            out_nxt.label_size   = sat_size(b_cnt);
            out_nxt.label_weight = sat_sum(setw_sum);
            state_nxt            = S_IDLE;
          end
          LOP_XFER: begin
            lab_we      = 1'b1;
            lab_wa      = src_r;
            lab_wd      = {src_cnt_new, src_sum_new};
            dst_cnt_nxt = dst_cnt_new;
            dst_sum_nxt = dst_sum_new;
            used_nxt    = used_r;
            if (clr_src) begin
              used_nxt[src_r] = 1'b0;
            end
            if (d_cnt_r != '0) begin
              used_nxt[dst_r] = 1'b1;
            end
            used_cnt_nxt = used_cnt_r - UC_W'(clr_src) + UC_W'(set_dst);
            state_nxt    = S_WR2;
          end
          default: begin
            out_valid_nxt        = 1'b1;
            out_nxt.label        = 6'(dst_r);
            out_nxt.label_size   = sat_size(b_cnt);
            out_nxt.label_weight = sat_sum(b_sum);
            state_nxt            = S_IDLE;
          end
        endcase
      end

      S_WR2: begin
        lab_we               = 1'b1;
        lab_wa               = dst_r;
        lab_wd               = {dst_cnt_r, dst_sum_r};
        out_valid_nxt        = 1'b1;
        out_nxt.label        = 6'(dst_r);
        out_nxt.label_size   = sat_size(dst_cnt_r);
        out_nxt.label_weight = sat_sum(dst_sum_r);
        state_nxt            = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write stores the value and restarts the clearing pass.
    if (cfg_we && ((cfg_index == CFG_OBS_COUNT) || (cfg_index == CFG_LABEL_COUNT))) begin
      if (cfg_index == CFG_OBS_COUNT) begin
        obs_count_nxt = cfg_data[10:0];
      end else begin
        label_count_nxt = cfg_data[6:0];
      end
      idx_nxt       = '0;
      init_rep_nxt  = 1'b0;
      out_valid_nxt = 1'b0;
      state_nxt     = S_CLEAR;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      idx_r         <= '0;
      pend_r        <= 1'b0;
      used_r        <= MAX_LABELS'(1);
      used_cnt_r    <= UC_W'(1);
      obs_count_r   <= OBS_COUNT_RST;
      label_count_r <= LABEL_COUNT_RST;
      init_rep_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      pend_r        <= pend_nxt;
      used_r        <= used_nxt;
      used_cnt_r    <= used_cnt_nxt;
      obs_count_r   <= obs_count_nxt;
      label_count_r <= label_count_nxt;
      init_rep_r    <= init_rep_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    lop_r       <= lop_nxt;
    mode_r      <= mode_nxt;
    pend_addr_r <= pend_addr_nxt;
    obs_addr_r  <= obs_addr_nxt;
    src_r       <= src_nxt;
    dst_r       <= dst_nxt;
    new_w_r     <= new_w_nxt;
    d_cnt_r     <= d_cnt_nxt;
    d_w_r       <= d_w_nxt;
    dst_cnt_r   <= dst_cnt_nxt;
    dst_sum_r   <= dst_sum_nxt;
    out_r       <= out_nxt;
  end

  // Observation memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (obs_we) begin
      obs_mem[obs_wa] <= obs_wd;
    end
    obs_rdata_r <= obs_mem[obs_ra];
  end

  // Label memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    lab_rdata_a_r <= lab_mem[lab_ra_a];
    lab_rdata_b_r <= lab_mem[lab_ra_b];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* src/wplt_checker.sv */
`timescale 1ns / 1ps

module wplt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input wplt_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input wplt_pkg::out_item_t             out_data,
  input logic                            cfg_we,
  input logic [wplt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [wplt_pkg::CFG_DATA_W-1:0] cfg_data
);

  import wplt_pkg::*;

  // A register write always starts the clearing pass.
  property p_cfg_clears;
    @(posedge clk) disable iff (!rst_n)
      cfg_we && ((cfg_index == CFG_OBS_COUNT) || (cfg_index == CFG_LABEL_COUNT)) |=> busy;
  endproperty
  a_cfg_clears: assert property (p_cfg_clears)
    else $error("register write did not start the clearing pass");

  // A rejected transaction reports no label data.
  property p_err_zero;
    @(posedge clk) disable iff (!rst_n)
      out_valid && (out_data.status == STATUS_ERR) |->
        (out_data.label == 6'd0) && (out_data.label_size == 11'd0) &&
        (out_data.label_weight == 26'd0);
  endproperty
  a_err_zero: assert property (p_err_zero)
    else $error("error result carries label data");

  // The running count of used labels matches the mask.
  property p_used_count;
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> (32'(out_data.used_count) == $countones(out_data.used_mask));
  endproperty
  a_used_count: assert property (p_used_count)
    else $error("used label count disagrees with used mask");

  // The reported label is marked used exactly when it has members.
  property p_used_bit;
    @(posedge clk) disable iff (!rst_n)
      out_valid && (out_data.status == STATUS_OK) |->
        ((out_data.label_size != 11'd0) == out_data.used_mask[out_data.label]);
  endproperty
  a_used_bit: assert property (p_used_bit)
    else $error("used bit of reported label disagrees with its size");

endmodule

bind weighted_partition_label_table wplt_checker u_wplt_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import wplt_pkg::*;

  localparam int TB_MAX_OBS    = 1024;
  localparam int TB_MAX_LABELS = 64;
  // Longest quiet stretch of a correct run is a full-table merge or clearing pass.
  localparam int QUIET_LIMIT   = 8000;
  localparam int DRAIN_CYCLES  = 1100;

  // Register indexes past the end of the register list.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  // Mode codes with no operation of their own; they behave as a query.
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        idle_pct     = 37;
  out_item_t pending_results[$];

  // Shadow copy of the partition and of the size registers.
  logic [10:0]  obs_count_reg;
  logic [6:0]   label_count_reg;
  logic [5:0]   obs_label_m   [TB_MAX_OBS];
  logic [15:0]  obs_weight_m  [TB_MAX_OBS];
  int unsigned  label_members_m [TB_MAX_LABELS];
  logic [63:0]  label_sum_m   [TB_MAX_LABELS];
  logic [63:0]  used_labels_m;

  weighted_partition_label_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Observation count in use, with zero and oversize values clamped.
  function automatic int active_obs();
    if (obs_count_reg == 0) return 1;
    if (obs_count_reg > TB_MAX_OBS) return TB_MAX_OBS;
    return obs_count_reg;
  endfunction

  // Label count in use, with zero and oversize values clamped.
  function automatic int active_labels();
    if (label_count_reg == 0) return 1;
    if (label_count_reg > TB_MAX_LABELS) return TB_MAX_LABELS;
    return label_count_reg;
  endfunction

  // Every observation back in label 0 with unit weight.
  function automatic void clear_partition();
    int i;
    for (i = 0; i < TB_MAX_OBS; i++) begin
      obs_label_m[i]  = '0;
      obs_weight_m[i] = 16'd1;
    end
    for (i = 0; i < TB_MAX_LABELS; i++) begin
      label_members_m[i] = 0;
      label_sum_m[i]     = '0;
    end
    label_members_m[0] = active_obs();
    label_sum_m[0]     = active_obs();
    used_labels_m      = 64'd1;
  endfunction

  // Move one observation to another label, keeping counts, sums and used bits.
  function automatic void relabel_obs(int o, int to);
    int          from;
    logic [15:0] w;
    from = obs_label_m[o];
    w    = obs_weight_m[o];
    if (from == to) return;
    if (label_members_m[from] > 0) label_members_m[from]--;
    label_sum_m[from] -= w;
    if (label_members_m[from] == 0) used_labels_m[from] = 1'b0;
    label_members_m[to]++;
    label_sum_m[to] += w;
    used_labels_m[to] = 1'b1;
    obs_label_m[o] = to[5:0];
  endfunction

  // Apply one command to the shadow table and return the result it must give.
  function automatic out_item_t predict_table_step(in_item_t c);
    out_item_t r;
    int        n_obs, n_lab, rep, dst, src, l, i;
    bit        err;
    n_obs = active_obs();
    n_lab = active_labels();
    err   = 1'b0;
    rep   = 0;
    case (c.mode)
      MODE_INIT: begin
        clear_partition();
      end
      MODE_MOVE: begin
        if (c.obs >= n_obs || c.label_a >= n_lab) begin
          err = 1'b1;
        end else begin
          relabel_obs(c.obs, c.label_a);
          rep = c.label_a;
        end
      end
      MODE_MERGE: begin
        if (c.label_a >= n_lab || c.label_b >= n_lab) begin
          err = 1'b1;
        end else begin
          dst = (c.label_a < c.label_b) ? c.label_a : c.label_b;
          src = (c.label_a < c.label_b) ? c.label_b : c.label_a;
          if (dst != src) begin
            for (i = 0; i < n_obs; i++) begin
              if (obs_label_m[i] == src) relabel_obs(i, dst);
            end
          end
          rep = dst;
        end
      end
      MODE_SETW: begin
        if (c.obs >= n_obs) begin
          err = 1'b1;
        end else begin
          l = obs_label_m[c.obs];
          label_sum_m[l] = label_sum_m[l] - obs_weight_m[c.obs] + c.weight;
          obs_weight_m[c.obs] = c.weight;
          rep = l;
        end
      end
      default: begin
        if (c.obs >= n_obs) err = 1'b1;
        else rep = obs_label_m[c.obs];
      end
    endcase

    r.status = err ? STATUS_ERR : STATUS_OK;
    if (err) begin
      r.label        = '0;
      r.label_size   = '0;
      r.label_weight = '0;
    end else begin
      r.label        = rep[5:0];
      r.label_size   = (label_members_m[rep] > SIZE_MAX_OUT) ? SIZE_MAX_OUT :
                       11'(label_members_m[rep]);
      r.label_weight = (label_sum_m[rep] > SUM_MAX_OUT) ? SUM_MAX_OUT :
                       label_sum_m[rep][25:0];
    end
    r.used_count = 7'($countones(used_labels_m));
    r.used_mask  = used_labels_m;
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [2:0] m, logic [9:0] o, logic [5:0] a,
                                        logic [5:0] b, logic [15:0] w);
    in_item_t it;
    it.mode    = m;
    it.obs     = o;
    it.label_a = a;
    it.label_b = b;
    it.weight  = w;
    return it;
  endfunction

  // Mostly a label in range, sometimes any 6-bit value.
  function automatic logic [5:0] rand_label(int n);
    return ($urandom_range(99) < 85) ? 6'($urandom_range(n - 1)) : 6'($urandom);
  endfunction

  // Offer one command, hold it until the block takes it, then record its result.
  task automatic send_cmd(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do begin
      @(posedge clk);
    end while (busy);
    pending_results.push_back(predict_table_step(it));
  endtask

  // Stop offering commands and wait until every result is in and the block is free.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Write one size register; a valid index also rebuilds the table.
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_OBS_COUNT: begin
        obs_count_reg = val;
        clear_partition();
      end
      CFG_LABEL_COUNT: begin
        label_count_reg = val[6:0];
        clear_partition();
      end
      default: ;
    endcase
  endtask

  // Every mode on the full-size table after reset.
  task automatic test_directed_modes();
    send_cmd(make_cmd(MODE_QUERY, 10'd0,    6'd0,  6'd0,  16'd0));
    send_cmd(make_cmd(MODE_QUERY, 10'd1023, 6'd0,  6'd0,  16'd0));
    send_cmd(make_cmd(MODE_MOVE,  10'd5,    6'd63, 6'd0,  16'd0));
    // Moving to the label it already has changes nothing.
    send_cmd(make_cmd(MODE_MOVE,  10'd5,    6'd63, 6'd0,  16'd0));
    send_cmd(make_cmd(MODE_SETW,  10'd5,    6'd0,  6'd0,  16'hFFFF));
    send_cmd(make_cmd(MODE_SETW,  10'd1023, 6'd0,  6'd0,  16'h0000));
    send_cmd(make_cmd(MODE_MOVE,  10'd1023, 6'd63, 6'd0,  16'd0));
    // The higher label drains into the lower one, whichever field holds it.
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd63, 6'd10, 16'd0));
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd10, 6'd10, 16'd0));
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd0,  6'd10, 16'd0));
    send_cmd(make_cmd(MODE_MOVE,  10'd7,    6'd1,  6'd0,  16'd0));
    send_cmd(make_cmd(MODE_SETW,  10'd7,    6'd0,  6'd0,  16'hAAAA));
    send_cmd(make_cmd(MODE_MOVE,  10'd8,    6'd2,  6'd0,  16'd0));
    send_cmd(make_cmd(MODE_SETW,  10'd8,    6'd0,  6'd0,  16'h5555));
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd2,  6'd1,  16'd0));
    send_cmd(make_cmd(MODE_RSVD5, 10'd8,    6'h3F, 6'h3F, 16'hFFFF));
    send_cmd(make_cmd(MODE_RSVD6, 10'd7,    6'h2A, 6'h15, 16'h1234));
    send_cmd(make_cmd(MODE_RSVD7, 10'h3FF,  6'h00, 6'h3F, 16'h0000));
    send_cmd(make_cmd(MODE_INIT,  10'd0,    6'd0,  6'd0,  16'd0));
    send_cmd(make_cmd(MODE_QUERY, 10'd5,    6'd0,  6'd0,  16'd0));
  endtask

  // Clamping of the size registers, out-of-range indexes and unused register indexes.
  task automatic test_register_limits();
    // A zero observation count acts as one; a single label is available.
    write_reg(CFG_OBS_COUNT,   11'd0);
    write_reg(CFG_LABEL_COUNT, 11'd1);
    send_cmd(make_cmd(MODE_QUERY, 10'd0,    6'd0,  6'd0, 16'd0));
    send_cmd(make_cmd(MODE_QUERY, 10'd1,    6'd0,  6'd0, 16'd0));
    send_cmd(make_cmd(MODE_MOVE,  10'd0,    6'd1,  6'd0, 16'd0));
    send_cmd(make_cmd(MODE_MOVE,  10'd1023, 6'd0,  6'd0, 16'd0));
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd0,  6'd1, 16'd0));
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd63, 6'd0, 16'd0));
    send_cmd(make_cmd(MODE_SETW,  10'd1,    6'd0,  6'd0, 16'h1234));
    send_cmd(make_cmd(MODE_SETW,  10'd0,    6'd0,  6'd0, 16'hFFFF));
    send_cmd(make_cmd(MODE_MERGE, 10'd0,    6'd0,  6'd0, 16'd0));

    // Writes past the register list must keep the weight set above.
    write_reg(CFG_SPARE_A, 11'h7FF);
    write_reg(CFG_SPARE_B, 11'h000);
    send_cmd(make_cmd(MODE_QUERY, 10'd0, 6'd0, 6'd0, 16'd0));

    // Oversize counts clamp to the table limits.
    write_reg(CFG_OBS_COUNT,   11'h7FF);
    write_reg(CFG_LABEL_COUNT, 11'd127);
    send_cmd(make_cmd(MODE_QUERY, 10'd1023, 6'd0,  6'd0, 16'd0));
    send_cmd(make_cmd(MODE_MOVE,  10'd1023, 6'd63, 6'd0, 16'd0));

    // Only the low seven bits of the label count are kept, so this is zero.
    write_reg(CFG_LABEL_COUNT, 11'h400);
    send_cmd(make_cmd(MODE_MOVE,  10'd3, 6'd1, 6'd0, 16'd0));
    send_cmd(make_cmd(MODE_QUERY, 10'd3, 6'd0, 6'd0, 16'd0));
  endtask

  // Random commands at one table size, mostly with indexes in range.
  task automatic test_random_traffic(int n_obs_cfg, int n_lab_cfg, int n_items);
    in_item_t it;
    int       n_obs, n_lab, pick, k;
    write_reg(CFG_OBS_COUNT,   11'(n_obs_cfg));
    write_reg(CFG_LABEL_COUNT, 11'(n_lab_cfg));
    n_obs = active_obs();
    n_lab = active_labels();
    for (k = 0; k < n_items; k++) begin
      it.obs     = ($urandom_range(99) < 85) ? 10'($urandom_range(n_obs - 1)) :
                   10'($urandom);
      it.label_a = rand_label(n_lab);
      it.label_b = rand_label(n_lab);
      it.weight  = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 3) it.mode = MODE_INIT;
      else if (pick < 33) it.mode = MODE_MOVE;
      else if (pick < 45) it.mode = MODE_MERGE;
      else if (pick < 68) it.mode = MODE_SETW;
      else if (pick < 92) it.mode = MODE_QUERY;
      else it.mode = 3'($urandom_range(7));
      send_cmd(it);
    end
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no command pending: %p", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.label !== want.label) begin
          $error("label: expected %0d, got %0d", want.label, out_data.label);
          fail_count++;
        end
        if (out_data.label_size !== want.label_size) begin
          $error("label_size: expected %0d, got %0d", want.label_size,
                 out_data.label_size);
          fail_count++;
        end
        if (out_data.label_weight !== want.label_weight) begin
          $error("label_weight: expected %0d, got %0d", want.label_weight,
                 out_data.label_weight);
          fail_count++;
        end
        if (out_data.used_count !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count,
                 out_data.used_count);
          fail_count++;
        end
        if (out_data.used_mask !== want.used_mask) begin
          $error("used_mask: expected %h, got %h", want.used_mask, out_data.used_mask);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction or register write happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("weighted_partition_label_table test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    obs_count_reg   = OBS_COUNT_RST;
    label_count_reg = LABEL_COUNT_RST;
    clear_partition();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_modes();
    test_register_limits();

    idle_pct = 37;
    test_random_traffic(8, 4, 100);
    // Back-to-back commands with no gaps from the sender.
    idle_pct = 0;
    test_random_traffic(64, 16, 120);
    idle_pct = 37;
    test_random_traffic(1, 64, 40);
    test_random_traffic(1024, 64, 90);
    test_random_traffic(300, 2, 80);
    test_random_traffic(1023, 63, 100);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("weighted_partition_label_table test passed");
    end else begin
      $display("weighted_partition_label_table test failed");
    end
    $finish;
  end

endmodule
